>>> design/sli_pkg.sv
package sli_pkg;

  // Coordinate width: the low CW bits of each input coordinate are used.
  localparam int CW   = 32;
  localparam int InW  = 32;
  localparam int OutW = 64;

  // Difference width, product width and the width of den, num and the
  // vertical-case numerators.
  localparam int DFW = CW + 1;
  localparam int PW  = 2 * CW + 2;
  localparam int DW  = 2 * CW + 3;
  // Low part of den and num when they are split for the multipliers.
  localparam int HL  = CW + 2;
  localparam int PPW = 2 * CW + 4;
  // Full crossing numerator width.
  localparam int NW  = 3 * CW + 5;
  // Quotient bits that are resolved exactly; anything larger lies outside
  // every bounding box and is only flagged as an overflow.
  localparam int QB  = CW + 1;
  localparam int QS  = CW + 2;
  // Width of the saturation compare against d * 2^63.
  localparam int SW  = DW + OutW + 1;

  typedef struct packed {
    logic                 have;
    logic                 inc;
    logic                 sat;
    logic                 neg_x;
    logic                 neg_y;
    logic                 ovf_x;
    logic                 ovf_y;
    logic                 skip_s;
    logic                 skip_e;
    logic signed [CW-1:0] ax0;
    logic signed [CW-1:0] ay0;
    logic signed [CW-1:0] ax1;
    logic signed [CW-1:0] ay1;
  } sli_side_t;

  typedef struct packed {
    logic [NW-1:0] un_x;
    logic [DW-1:0] ud_x;
    logic [NW-1:0] un_y;
    logic [DW-1:0] ud_y;
    sli_side_t     side;
  } sli_div_in_t;

  typedef struct packed {
    logic [QB-1:0] q_x;
    logic [QB-1:0] q_y;
    sli_side_t     side;
  } sli_div_out_t;

endpackage

>>> design/sli_in_if.sv
interface sli_in_if;
  logic                      valid;
  logic                      ready;
  logic [sli_pkg::InW-1:0]   a_start_x;
  logic [sli_pkg::InW-1:0]   a_start_y;
  logic [sli_pkg::InW-1:0]   a_end_x;
  logic [sli_pkg::InW-1:0]   a_end_y;
  logic [sli_pkg::InW-1:0]   b_start_x;
  logic [sli_pkg::InW-1:0]   b_start_y;
  logic [sli_pkg::InW-1:0]   b_end_x;
  logic [sli_pkg::InW-1:0]   b_end_y;
  logic                      skip_start;
  logic                      skip_end;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
    output b_start_x, b_start_y, b_end_x, b_end_y, skip_start, skip_end,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
    input  b_start_x, b_start_y, b_end_x, b_end_y, skip_start, skip_end,
    output ready
  );
endinterface

>>> design/sli_out_if.sv
interface sli_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic                       incident;
  logic                       at_endpoint;
  logic [sli_pkg::OutW-1:0]   cross_x;
  logic [sli_pkg::OutW-1:0]   cross_y;
  logic                       saturated;

  modport source (
    output valid, hit, incident, at_endpoint, cross_x, cross_y, saturated,
    input  ready
  );
  modport sink (
    input  valid, hit, incident, at_endpoint, cross_x, cross_y, saturated,
    output ready
  );
endinterface

>>> design/sli_divider.sv
module sli_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  sli_pkg::sli_div_in_t  data_i,
  output logic                  valid_o,
  output sli_pkg::sli_div_out_t data_o
);

  localparam int NW = sli_pkg::NW;
  localparam int DW = sli_pkg::DW;
  localparam int QB = sli_pkg::QB;

  typedef struct packed {
    logic [NW-1:0]      rem_x;
    logic [NW-1:0]      rem_y;
    logic [DW-1:0]      ud_x;
    logic [DW-1:0]      ud_y;
    logic [QB-1:0]      q_x;
    logic [QB-1:0]      q_y;
    sli_pkg::sli_side_t side;
  } dstage_t;

  dstage_t       st_d [QB];
  dstage_t       st_q [QB];
  logic [QB-1:0] vld_q;

  // Restoring division, one quotient bit per stage, most significant first.
  always_comb begin
    dstage_t       src;
    logic [NW-1:0] dsh_x;
    logic [NW-1:0] dsh_y;
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        src.rem_x = data_i.un_x;
        src.rem_y = data_i.un_y;
        src.ud_x  = data_i.ud_x;
        src.ud_y  = data_i.ud_y;
        src.q_x   = '0;
        src.q_y   = '0;
        src.side  = data_i.side;
      end else begin
        src = st_q[k-1];
      end
      st_d[k] = src;
      dsh_x = NW'(src.ud_x) << (QB - 1 - k);
      dsh_y = NW'(src.ud_y) << (QB - 1 - k);
      if (src.rem_x >= dsh_x) begin
        st_d[k].rem_x         = src.rem_x - dsh_x;
        st_d[k].q_x[QB-1-k]   = 1'b1;
      end
      if (src.rem_y >= dsh_y) begin
        st_d[k].rem_y         = src.rem_y - dsh_y;
        st_d[k].q_y[QB-1-k]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QB; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o     = vld_q[QB-1];
  assign data_o.q_x  = st_q[QB-1].q_x;
  assign data_o.q_y  = st_q[QB-1].q_y;
  assign data_o.side = st_q[QB-1].side;

endmodule

>>> design/segment_line_intersection.sv
// Channel | Modport           | Beat
// in_i    | sli_in_if.sink    | segment A, line B, skip_start, skip_end
// out_o   | sli_out_if.source | hit, incident, at_endpoint, cross_x, cross_y, saturated
//
// One beat is accepted every cycle while out_o is not stalled; each result passes
// through stages s1 to s8, the one-bit-per-stage divider and the result register.
// rst_ni clears every stage valid bit; payload registers are not reset.
// A stall on out_o freezes the whole pipeline in place, so in_i.ready drops
// in the same cycle and no beat is lost or repeated.
module segment_line_intersection (
  input  logic      clk_i,
  input  logic      rst_ni,
  sli_in_if.sink    in_i,
  sli_out_if.source out_o
);

  localparam int CW   = sli_pkg::CW;
  localparam int DFW  = sli_pkg::DFW;
  localparam int PW   = sli_pkg::PW;
  localparam int DW   = sli_pkg::DW;
  localparam int HL   = sli_pkg::HL;
  localparam int PPW  = sli_pkg::PPW;
  localparam int NW   = sli_pkg::NW;
  localparam int QB   = sli_pkg::QB;
  localparam int QS   = sli_pkg::QS;
  localparam int SW   = sli_pkg::SW;
  localparam int OutW = sli_pkg::OutW;

  // Stage 1: coordinates and their differences.
  typedef struct packed {
    logic signed [CW-1:0]  ax0, ay0, ax1, ay1, bx1, by1;
    logic signed [DFW-1:0] dxa, dya, dxb, dyb, e_ab, e_ba, f_x, f_y, g_y;
    logic                  skip_s, skip_e;
  } s1_t;

  // Stage 2: the pairwise products.
  typedef struct packed {
    logic signed [CW-1:0]  ax0, ay0, ax1, ay1, bx1;
    logic signed [DFW-1:0] dxa, dya, dxb;
    logic signed [PW-1:0]  p_den1, p_den2, p_ya1, p_ya2, p_yb1, p_yb2, p_inc1, p_n1, p_n2;
    logic                  avert, bvert, same_x, skip_s, skip_e;
  } s2_t;

  // Stage 3: determinant, crossing parameter and vertical-case numerators.
  typedef struct packed {
    logic signed [CW-1:0]  ax0, ay0, ax1, ay1, bx1;
    logic signed [DFW-1:0] dxa, dya, dxb;
    logic signed [DW-1:0]  den, num, nya, nyb;
    logic                  inc_eq, avert, bvert, same_x, skip_s, skip_e;
  } s3_t;

  // Stage 4: partial products of the wide multiplications.
  typedef struct packed {
    logic signed [CW-1:0]  ax0, ay0, ax1, ay1, bx1;
    logic signed [DFW-1:0] dxa, dxb;
    logic signed [DW-1:0]  den, nya, nyb;
    logic signed [PPW-1:0] xd_l, xd_h, yd_l, yd_h, xn_l, xn_h, yn_l, yn_h;
    logic                  inc_eq, den_zero, avert, bvert, same_x, skip_s, skip_e;
  } s4_t;

  // Stage 5: the four wide products reassembled.
  typedef struct packed {
    logic signed [CW-1:0]  ax0, ay0, ax1, ay1, bx1;
    logic signed [DFW-1:0] dxa, dxb;
    logic signed [DW-1:0]  den, nya, nyb;
    logic signed [NW-1:0]  t_xd, t_xn, t_yd, t_yn;
    logic                  inc_eq, den_zero, avert, bvert, same_x, skip_s, skip_e;
  } s5_t;

  // Stage 6: the selected dividend and divisor for each coordinate.
  typedef struct packed {
    logic signed [CW-1:0] ax0, ay0, ax1, ay1;
    logic signed [NW-1:0] n_x, n_y;
    logic signed [DW-1:0] d_x, d_y;
    logic                 have, inc, skip_s, skip_e;
  } s6_t;

  // Stage 7: magnitudes and quotient signs.
  typedef struct packed {
    logic signed [CW-1:0] ax0, ay0, ax1, ay1;
    logic [NW-1:0]        un_x, un_y;
    logic [DW-1:0]        ud_x, ud_y;
    logic                 neg_x, neg_y, have, inc, skip_s, skip_e;
  } s7_t;

  typedef struct packed {
    logic             hit;
    logic             inc;
    logic             endp;
    logic [OutW-1:0]  x;
    logic [OutW-1:0]  y;
    logic             sat;
  } res_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;
  s7_t s7_d, s7_q;
  sli_pkg::sli_div_in_t  s8_d, s8_q;
  sli_pkg::sli_div_out_t dv;
  res_t                  res_d, res_q;

  logic [7:0] vld_q;
  logic       dv_vld;
  logic       out_vld_q;
  logic       en;

  // The whole pipeline advances together unless the output beat is stalled.
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    logic signed [CW-1:0] bx0, by0;
    s1_d.ax0    = signed'(in_i.a_start_x[CW-1:0]);
    s1_d.ay0    = signed'(in_i.a_start_y[CW-1:0]);
    s1_d.ax1    = signed'(in_i.a_end_x[CW-1:0]);
    s1_d.ay1    = signed'(in_i.a_end_y[CW-1:0]);
    bx0         = signed'(in_i.b_start_x[CW-1:0]);
    by0         = signed'(in_i.b_start_y[CW-1:0]);
    s1_d.bx1    = signed'(in_i.b_end_x[CW-1:0]);
    s1_d.by1    = signed'(in_i.b_end_y[CW-1:0]);
    s1_d.dxa    = DFW'(s1_d.ax1) - DFW'(s1_d.ax0);
    s1_d.dya    = DFW'(s1_d.ay1) - DFW'(s1_d.ay0);
    s1_d.dxb    = DFW'(s1_d.bx1) - DFW'(bx0);
    s1_d.dyb    = DFW'(s1_d.by1) - DFW'(by0);
    s1_d.e_ab   = DFW'(s1_d.ax1) - DFW'(s1_d.bx1);
    s1_d.e_ba   = DFW'(s1_d.bx1) - DFW'(s1_d.ax1);
    s1_d.f_x    = DFW'(bx0) - DFW'(s1_d.ax0);
    s1_d.f_y    = DFW'(by0) - DFW'(s1_d.ay0);
    s1_d.g_y    = DFW'(s1_d.by1) - DFW'(s1_d.ay1);
    s1_d.skip_s = in_i.skip_start;
    s1_d.skip_e = in_i.skip_end;
  end

  always_comb begin
    s2_d.ax0    = s1_q.ax0;
    s2_d.ay0    = s1_q.ay0;
    s2_d.ax1    = s1_q.ax1;
    s2_d.ay1    = s1_q.ay1;
    s2_d.bx1    = s1_q.bx1;
    s2_d.dxa    = s1_q.dxa;
    s2_d.dya    = s1_q.dya;
    s2_d.dxb    = s1_q.dxb;
    s2_d.p_den1 = s1_q.dxa * s1_q.dyb;
    s2_d.p_den2 = s1_q.dya * s1_q.dxb;
    s2_d.p_ya1  = s1_q.by1 * s1_q.dxb;
    s2_d.p_ya2  = s1_q.dyb * s1_q.e_ab;
    s2_d.p_yb1  = s1_q.ay1 * s1_q.dxa;
    s2_d.p_yb2  = s1_q.dya * s1_q.e_ba;
    s2_d.p_inc1 = s1_q.g_y * s1_q.dxa;
    s2_d.p_n1   = s1_q.f_x * s1_q.dyb;
    s2_d.p_n2   = s1_q.f_y * s1_q.dxb;
    s2_d.avert  = (s1_q.dxa == '0);
    s2_d.bvert  = (s1_q.dxb == '0);
    s2_d.same_x = (s1_q.ax0 == s1_q.bx1 - s1_q.dxb);
    s2_d.skip_s = s1_q.skip_s;
    s2_d.skip_e = s1_q.skip_e;
  end

  always_comb begin
    s3_d.ax0    = s2_q.ax0;
    s3_d.ay0    = s2_q.ay0;
    s3_d.ax1    = s2_q.ax1;
    s3_d.ay1    = s2_q.ay1;
    s3_d.bx1    = s2_q.bx1;
    s3_d.dxa    = s2_q.dxa;
    s3_d.dya    = s2_q.dya;
    s3_d.dxb    = s2_q.dxb;
    s3_d.den    = DW'(s2_q.p_den1) - DW'(s2_q.p_den2);
    s3_d.num    = DW'(s2_q.p_n1) - DW'(s2_q.p_n2);
    s3_d.nya    = DW'(s2_q.p_ya1) + DW'(s2_q.p_ya2);
    s3_d.nyb    = DW'(s2_q.p_yb1) + DW'(s2_q.p_yb2);
    // The parallel lines coincide when B's end lies on line A.
    s3_d.inc_eq = (s2_q.p_inc1 == s2_q.p_yb2);
    s3_d.avert  = s2_q.avert;
    s3_d.bvert  = s2_q.bvert;
    s3_d.same_x = s2_q.same_x;
    s3_d.skip_s = s2_q.skip_s;
    s3_d.skip_e = s2_q.skip_e;
  end

  always_comb begin
    logic signed [HL:0]     den_lo, num_lo;
    logic signed [DW-HL-1:0] den_hi, num_hi;
    den_lo = signed'({1'b0, s3_q.den[HL-1:0]});
    num_lo = signed'({1'b0, s3_q.num[HL-1:0]});
    den_hi = signed'(s3_q.den[DW-1:HL]);
    num_hi = signed'(s3_q.num[DW-1:HL]);
    s4_d.ax0      = s3_q.ax0;
    s4_d.ay0      = s3_q.ay0;
    s4_d.ax1      = s3_q.ax1;
    s4_d.ay1      = s3_q.ay1;
    s4_d.bx1      = s3_q.bx1;
    s4_d.dxa      = s3_q.dxa;
    s4_d.dxb      = s3_q.dxb;
    s4_d.den      = s3_q.den;
    s4_d.nya      = s3_q.nya;
    s4_d.nyb      = s3_q.nyb;
    s4_d.xd_l     = s3_q.ax0 * den_lo;
    s4_d.xd_h     = s3_q.ax0 * den_hi;
    s4_d.yd_l     = s3_q.ay0 * den_lo;
    s4_d.yd_h     = s3_q.ay0 * den_hi;
    s4_d.xn_l     = s3_q.dxa * num_lo;
    s4_d.xn_h     = s3_q.dxa * num_hi;
    s4_d.yn_l     = s3_q.dya * num_lo;
    s4_d.yn_h     = s3_q.dya * num_hi;
    s4_d.inc_eq   = s3_q.inc_eq;
    s4_d.den_zero = (s3_q.den == '0);
    s4_d.avert    = s3_q.avert;
    s4_d.bvert    = s3_q.bvert;
    s4_d.same_x   = s3_q.same_x;
    s4_d.skip_s   = s3_q.skip_s;
    s4_d.skip_e   = s3_q.skip_e;
  end

  always_comb begin
    s5_d.ax0      = s4_q.ax0;
    s5_d.ay0      = s4_q.ay0;
    s5_d.ax1      = s4_q.ax1;
    s5_d.ay1      = s4_q.ay1;
    s5_d.bx1      = s4_q.bx1;
    s5_d.dxa      = s4_q.dxa;
    s5_d.dxb      = s4_q.dxb;
    s5_d.den      = s4_q.den;
    s5_d.nya      = s4_q.nya;
    s5_d.nyb      = s4_q.nyb;
    s5_d.t_xd     = (NW'(s4_q.xd_h) <<< HL) + NW'(s4_q.xd_l);
    s5_d.t_xn     = (NW'(s4_q.xn_h) <<< HL) + NW'(s4_q.xn_l);
    s5_d.t_yd     = (NW'(s4_q.yd_h) <<< HL) + NW'(s4_q.yd_l);
    s5_d.t_yn     = (NW'(s4_q.yn_h) <<< HL) + NW'(s4_q.yn_l);
    s5_d.inc_eq   = s4_q.inc_eq;
    s5_d.den_zero = s4_q.den_zero;
    s5_d.avert    = s4_q.avert;
    s5_d.bvert    = s4_q.bvert;
    s5_d.same_x   = s4_q.same_x;
    s5_d.skip_s   = s4_q.skip_s;
    s5_d.skip_e   = s4_q.skip_e;
  end

  // Case selection. A vertical line fixes x exactly, which is expressed as a
  // division by one so that both coordinates share the same divider.
  always_comb begin
    s6_d.ax0    = s5_q.ax0;
    s6_d.ay0    = s5_q.ay0;
    s6_d.ax1    = s5_q.ax1;
    s6_d.ay1    = s5_q.ay1;
    s6_d.skip_s = s5_q.skip_s;
    s6_d.skip_e = s5_q.skip_e;
    s6_d.n_x    = s5_q.t_xd + s5_q.t_xn;
    s6_d.n_y    = s5_q.t_yd + s5_q.t_yn;
    s6_d.d_x    = s5_q.den;
    s6_d.d_y    = s5_q.den;
    s6_d.have   = 1'b1;
    s6_d.inc    = 1'b0;
    if (s5_q.avert && s5_q.bvert) begin
      s6_d.have = 1'b0;
      s6_d.inc  = s5_q.same_x;
    end else if (s5_q.avert) begin
      s6_d.n_x = NW'(s5_q.ax1);
      s6_d.d_x = DW'(1);
      s6_d.n_y = NW'(s5_q.nya);
      s6_d.d_y = DW'(s5_q.dxb);
    end else if (s5_q.bvert) begin
      s6_d.n_x = NW'(s5_q.bx1);
      s6_d.d_x = DW'(1);
      s6_d.n_y = NW'(s5_q.nyb);
      s6_d.d_y = DW'(s5_q.dxa);
    end else if (s5_q.den_zero) begin
      s6_d.have = 1'b0;
      s6_d.inc  = s5_q.inc_eq;
    end
  end

  always_comb begin
    s7_d.ax0    = s6_q.ax0;
    s7_d.ay0    = s6_q.ay0;
    s7_d.ax1    = s6_q.ax1;
    s7_d.ay1    = s6_q.ay1;
    s7_d.have   = s6_q.have;
    s7_d.inc    = s6_q.inc;
    s7_d.skip_s = s6_q.skip_s;
    s7_d.skip_e = s6_q.skip_e;
    s7_d.un_x   = s6_q.n_x[NW-1] ? NW'(-s6_q.n_x) : NW'(s6_q.n_x);
    s7_d.un_y   = s6_q.n_y[NW-1] ? NW'(-s6_q.n_y) : NW'(s6_q.n_y);
    s7_d.ud_x   = s6_q.d_x[DW-1] ? DW'(-s6_q.d_x) : DW'(s6_q.d_x);
    s7_d.ud_y   = s6_q.d_y[DW-1] ? DW'(-s6_q.d_y) : DW'(s6_q.d_y);
    s7_d.neg_x  = s6_q.n_x[NW-1] ^ s6_q.d_x[DW-1];
    s7_d.neg_y  = s6_q.n_y[NW-1] ^ s6_q.d_y[DW-1];
  end

  // Range checks before the divider. A quotient of 2^63 or more saturates
  // when positive; a negative one saturates only beyond 2^63.
  always_comb begin
    logic [SW-1:0] lim_x, lim_y;
    logic          sat_x, sat_y;
    lim_x = SW'(s7_q.ud_x) << (OutW - 1);
    lim_y = SW'(s7_q.ud_y) << (OutW - 1);
    sat_x = s7_q.neg_x ? (SW'(s7_q.un_x) >= lim_x + SW'(s7_q.ud_x))
                       : (SW'(s7_q.un_x) >= lim_x);
    sat_y = s7_q.neg_y ? (SW'(s7_q.un_y) >= lim_y + SW'(s7_q.ud_y))
                       : (SW'(s7_q.un_y) >= lim_y);
    s8_d.un_x        = s7_q.un_x;
    s8_d.ud_x        = s7_q.ud_x;
    s8_d.un_y        = s7_q.un_y;
    s8_d.ud_y        = s7_q.ud_y;
    s8_d.side.have   = s7_q.have;
    s8_d.side.inc    = s7_q.inc;
    s8_d.side.sat    = s7_q.have && (sat_x || sat_y);
    s8_d.side.neg_x  = s7_q.neg_x;
    s8_d.side.neg_y  = s7_q.neg_y;
    s8_d.side.ovf_x  = s7_q.un_x >= (NW'(s7_q.ud_x) << QB);
    s8_d.side.ovf_y  = s7_q.un_y >= (NW'(s7_q.ud_y) << QB);
    s8_d.side.skip_s = s7_q.skip_s;
    s8_d.side.skip_e = s7_q.skip_e;
    s8_d.side.ax0    = s7_q.ax0;
    s8_d.side.ay0    = s7_q.ay0;
    s8_d.side.ax1    = s7_q.ax1;
    s8_d.side.ay1    = s7_q.ay1;
  end

  sli_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[7]),
    .data_i  (s8_q),
    .valid_o (dv_vld),
    .data_o  (dv)
  );

  // Bounding box and endpoint tests on the signed quotients.
  always_comb begin
    logic signed [QS-1:0] qx, qy, mx, my;
    logic signed [CW-1:0] minx, maxx, miny, maxy;
    logic                 in_box;
    mx   = signed'({1'b0, dv.q_x});
    my   = signed'({1'b0, dv.q_y});
    qx   = dv.side.neg_x ? -mx : mx;
    qy   = dv.side.neg_y ? -my : my;
    minx = (dv.side.ax0 < dv.side.ax1) ? dv.side.ax0 : dv.side.ax1;
    maxx = (dv.side.ax0 < dv.side.ax1) ? dv.side.ax1 : dv.side.ax0;
    miny = (dv.side.ay0 < dv.side.ay1) ? dv.side.ay0 : dv.side.ay1;
    maxy = (dv.side.ay0 < dv.side.ay1) ? dv.side.ay1 : dv.side.ay0;
    in_box = !dv.side.ovf_x && !dv.side.ovf_y &&
             (qx >= minx) && (qx <= maxx) && (qy >= miny) && (qy <= maxy);
    res_d.inc  = dv.side.inc;
    res_d.sat  = dv.side.sat;
    res_d.endp = 1'b0;
    res_d.hit  = dv.side.inc;
    if (dv.side.have && in_box) begin
      res_d.hit = 1'b1;
      if (qx == dv.side.ax0 && qy == dv.side.ay0) begin
        if (dv.side.skip_s) res_d.hit = 1'b0;
        else res_d.endp = 1'b1;
      end else if (qx == dv.side.ax1 && qy == dv.side.ay1) begin
        if (dv.side.skip_e) res_d.hit = 1'b0;
        else res_d.endp = 1'b1;
      end
    end
    res_d.x = (dv.side.have && res_d.hit) ? OutW'(qx) : '0;
    res_d.y = (dv.side.have && res_d.hit) ? OutW'(qy) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[6:0], in_i.valid};
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      s5_q  <= s5_d;
      s6_q  <= s6_d;
      s7_q  <= s7_d;
      s8_q  <= s8_d;
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.hit         = res_q.hit;
  assign out_o.incident    = res_q.inc;
  assign out_o.at_endpoint = res_q.endp;
  assign out_o.cross_x     = res_q.x;
  assign out_o.cross_y     = res_q.y;
  assign out_o.saturated   = res_q.sat;

  // An incident result is always a hit and never carries a point.
  a_inc_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.inc |-> res_q.hit && !res_q.sat && !res_q.endp)
    else $error("incident result without hit or with point flags");

  // A miss carries no crossing point.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.hit |-> res_q.x == '0 && res_q.y == '0 && !res_q.endp)
    else $error("miss with nonzero crossing point");

  // A saturated crossing always lies outside the bounding box.
  a_sat_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.sat |-> !res_q.hit)
    else $error("saturated crossing reported as hit");

  // A stalled pipeline holds its stage valid bits and the output valid.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(out_vld_q))
    else $error("pipeline moved during a stall");

endmodule

>>> test/tb_top.sv
// Testbench for segment_line_intersection.
//
// Every accepted input beat is run through a local predictor that does the
// crossing math exactly, in 128-bit signed integers. The expected crossing
// record is then queued in arrival order. A checker process pops the oldest
// record for every result beat and compares it field by field.
//
// The block keeps no state from one beat to the next, so each beat stands alone. The
// interesting behavior all lives in the geometry:
//   - both lines vertical,
//   - only one line vertical,
//   - parallel lines, coincident or apart,
//   - a general crossing, inside or outside A's bounding box,
//   - a crossing on an endpoint, with and without the skip flags,
//   - degenerate segments,
//   - coordinates large enough that the crossing clamps to 64 bits.
module tb_top;

  localparam int InW  = sli_pkg::InW;
  localparam int OutW = sli_pkg::OutW;

  typedef logic signed [127:0] wide_t;

  // One input beat: segment A, line B and the two skip flags.
  typedef struct {
    logic signed [InW-1:0] ax0, ay0, ax1, ay1;
    logic signed [InW-1:0] bx0, by0, bx1, by1;
    logic                  skip_s, skip_e;
  } seg_pair_t;

  // One result beat, as the block should report it.
  typedef struct {
    logic             hit, incident, at_endpoint, saturated;
    logic [OutW-1:0]  cross_x, cross_y;
  } crossing_t;

  localparam wide_t MAX64 = wide_t'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam wide_t MIN64 = -MAX64 - 1;

  logic clk;
  logic rst_n;

  sli_in_if  in_if ();
  sli_out_if out_if ();

  segment_line_intersection dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Expected crossings, oldest first.
  crossing_t pending_crossings[$];
  int        mismatches = 0;

  // Idle rates, in percent, for the sender and the receiver.
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  // A request for a long receiver hold-off, in cycles.
  int        hold_request = 0;
  int        hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run ends here if the block stops making progress.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // Truncating division, clamped to the signed 64-bit range. SystemVerilog
  // division of signed operands already rounds toward zero.
  function automatic wide_t div_clamped(wide_t n, wide_t d, inout logic sat);
    wide_t q;
    q = n / d;
    if (q > MAX64) begin
      sat = 1'b1;
      q   = MAX64;
    end else if (q < MIN64) begin
      sat = 1'b1;
      q   = MIN64;
    end
    return q;
  endfunction

  // Works out the crossing of segment A with line B.
  function automatic crossing_t predict_crossing(seg_pair_t p);
    wide_t     ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    wide_t     dxa, dya, dxb, dyb, den, num, x, y;
    wide_t     minx, maxx, miny, maxy;
    logic      point, sat;
    crossing_t r;
    ax0 = p.ax0; ay0 = p.ay0; ax1 = p.ax1; ay1 = p.ay1;
    bx0 = p.bx0; by0 = p.by0; bx1 = p.bx1; by1 = p.by1;
    dxa = ax1 - ax0; dya = ay1 - ay0;
    dxb = bx1 - bx0; dyb = by1 - by0;
    r = '{default: '0};
    point = 1'b0;
    sat = 1'b0;
    x = 0;
    y = 0;
    if (dxa == 0 && dxb == 0) begin
      // Two vertical lines only meet when they share x.
      if (ax0 == bx0) begin
        r.hit = 1'b1;
        r.incident = 1'b1;
      end
    end else if (dxa == 0) begin
      x = ax1;
      y = div_clamped(by1 * dxb + dyb * (x - bx1), dxb, sat);
      point = 1'b1;
    end else if (dxb == 0) begin
      x = bx1;
      y = div_clamped(ay1 * dxa + dya * (x - ax1), dxa, sat);
      point = 1'b1;
    end else begin
      den = dxa * dyb - dya * dxb;
      if (den == 0) begin
        // Equal gradients: the lines coincide when B's point lies on A.
        if ((by1 - ay1) * dxa == dya * (bx1 - ax1)) begin
          r.hit = 1'b1;
          r.incident = 1'b1;
        end
      end else begin
        num = (bx0 - ax0) * dyb - (by0 - ay0) * dxb;
        x = div_clamped(ax0 * den + dxa * num, den, sat);
        y = div_clamped(ay0 * den + dya * num, den, sat);
        point = 1'b1;
      end
    end
    if (point) begin
      minx = (ax0 < ax1) ? ax0 : ax1;
      maxx = (ax0 < ax1) ? ax1 : ax0;
      miny = (ay0 < ay1) ? ay0 : ay1;
      maxy = (ay0 < ay1) ? ay1 : ay0;
      if (x >= minx && x <= maxx && y >= miny && y <= maxy) begin
        r.hit = 1'b1;
        // The start point is tested first, so a degenerate A is decided
        // by skip_start alone.
        if (x == ax0 && y == ay0) begin
          if (p.skip_s) r.hit = 1'b0;
          else r.at_endpoint = 1'b1;
        end else if (x == ax1 && y == ay1) begin
          if (p.skip_e) r.hit = 1'b0;
          else r.at_endpoint = 1'b1;
        end
      end
      if (r.hit) begin
        r.cross_x = x[OutW-1:0];
        r.cross_y = y[OutW-1:0];
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  // Offers one beat, idling first for a random number of cycles, and waits
  // for the block to take it. The expectation is queued just before the edge
  // at which the beat is accepted.
  task automatic send_pair(seg_pair_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.a_start_x  <= p.ax0;
    in_if.a_start_y  <= p.ay0;
    in_if.a_end_x    <= p.ax1;
    in_if.a_end_y    <= p.ay1;
    in_if.b_start_x  <= p.bx0;
    in_if.b_start_y  <= p.by0;
    in_if.b_end_x    <= p.bx1;
    in_if.b_end_y    <= p.by1;
    in_if.skip_start <= p.skip_s;
    in_if.skip_end   <= p.skip_e;
    do @(negedge clk); while (!in_if.ready);
    pending_crossings.insert(pending_crossings.size(), predict_crossing(p));
    @(posedge clk);
  endtask

  // Builds a pair from its eight coordinates and two skip flags.
  function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1, int bx0,
                                          int by0, int bx1, int by1, bit ss, bit se);
    seg_pair_t p;
    p.ax0 = ax0; p.ay0 = ay0; p.ax1 = ax1; p.ay1 = ay1;
    p.bx0 = bx0; p.by0 = by0; p.bx1 = bx1; p.by1 = by1;
    p.skip_s = ss;
    p.skip_e = se;
    return p;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 40)) - 20;
  endfunction

  // Random pair, weighted toward shapes that reach the special cases.
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int        dx, dy, k, m;
    p = make_pair(small_coord(), small_coord(), small_coord(), small_coord(),
                  small_coord(), small_coord(), small_coord(), small_coord(),
                  $urandom_range(0, 1), $urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1: begin
        p = make_pair($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 1), $urandom_range(0, 1));
      end
      3: p.ax1 = p.ax0;
      4: p.bx1 = p.bx0;
      5: begin
        p.ax1 = p.ax0;
        p.bx0 = ($urandom_range(0, 1) != 0) ? p.ax0 : p.ax0 + 1;
        p.bx1 = p.bx0;
      end
      6: begin
        // B parallel to A, either on the same line or shifted off it.
        dx = p.ax1 - p.ax0;
        dy = p.ay1 - p.ay0;
        k = int'($urandom_range(0, 4)) - 2;
        m = ($urandom_range(0, 1) != 0) ? 1 : -2;
        p.bx0 = p.ax0 + k * dx;
        p.by0 = p.ay0 + k * dy + int'($urandom_range(0, 1));
        p.bx1 = p.bx0 + m * dx;
        p.by1 = p.by0 + m * dy;
      end
      7: begin
        // B passes through one of A's endpoints.
        if ($urandom_range(0, 1) != 0) begin
          p.bx0 = p.ax0;
          p.by0 = p.ay0;
        end else begin
          p.bx0 = p.ax1;
          p.by0 = p.ay1;
        end
      end
      8: begin
        if ($urandom_range(0, 1) != 0) begin
          p.ax1 = p.ax0;
          p.ay1 = p.ay0;
        end else begin
          p.bx1 = p.bx0;
          p.by1 = p.by0;
        end
      end
      9: begin
        // Mix of extreme values and random words.
        p.ax0 = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : $urandom;
        p.by1 = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : $urandom;
        p.bx1 = ($urandom_range(0, 1) != 0) ? 32'h8000_0001 : $urandom;
        p.ay1 = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFE : $urandom;
      end
      default: ;
    endcase
    return p;
  endfunction

  // Receiver: random stalls, plus an occasional long hold-off.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Checker. Sampling at the falling edge sees what the next rising edge
  // will accept.
  always @(negedge clk) begin
    crossing_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_crossings.size() == 0) begin
        $display("%0t: result with nothing expected: hit=%0b x=%0d y=%0d", $time,
                 out_if.hit, $signed(out_if.cross_x), $signed(out_if.cross_y));
        mismatches++;
      end else begin
        want = pending_crossings.pop_front();
        if (out_if.hit !== want.hit || out_if.incident !== want.incident ||
            out_if.at_endpoint !== want.at_endpoint ||
            out_if.saturated !== want.saturated ||
            out_if.cross_x !== want.cross_x || out_if.cross_y !== want.cross_y) begin
          $display("%0t: expected hit=%0b inc=%0b endp=%0b sat=%0b x=%0d y=%0d",
                   $time, want.hit, want.incident, want.at_endpoint, want.saturated,
                   $signed(want.cross_x), $signed(want.cross_y));
          $display("%0t: actual   hit=%0b inc=%0b endp=%0b sat=%0b x=%0d y=%0d",
                   $time, out_if.hit, out_if.incident, out_if.at_endpoint,
                   out_if.saturated, $signed(out_if.cross_x), $signed(out_if.cross_y));
          mismatches++;
        end
      end
    end
  end

  // Each geometric case by hand, including the extremes.
  task automatic test_directed();
    // Both vertical, same x and different x.
    send_pair(make_pair(3, 0, 3, 9, 3, -5, 3, 7, 0, 0));
    send_pair(make_pair(3, 0, 3, 9, 4, -5, 4, 7, 0, 0));
    // A vertical, crossing inside and outside.
    send_pair(make_pair(2, -4, 2, 4, -3, -3, 5, 5, 0, 0));
    send_pair(make_pair(2, 5, 2, 9, -3, -3, 5, 5, 0, 0));
    // B vertical.
    send_pair(make_pair(-4, -4, 6, 6, 1, 10, 1, -10, 0, 0));
    // Parallel: coincident and apart.
    send_pair(make_pair(0, 0, 4, 2, 8, 4, 12, 6, 0, 0));
    send_pair(make_pair(0, 0, 4, 2, 8, 5, 12, 7, 0, 0));
    // General crossing with a truncated point, and one outside the box.
    send_pair(make_pair(0, 0, 7, 3, 0, 5, 5, -1, 0, 0));
    send_pair(make_pair(0, 0, 2, 1, 10, 0, 11, 9, 0, 0));
    // Crossing at A's start and end, with and without the skip flags.
    send_pair(make_pair(0, 0, 6, 6, 0, 0, 1, -1, 0, 0));
    send_pair(make_pair(0, 0, 6, 6, 0, 0, 1, -1, 1, 0));
    send_pair(make_pair(0, 0, 6, 6, 6, 6, 7, 5, 0, 0));
    send_pair(make_pair(0, 0, 6, 6, 6, 6, 7, 5, 0, 1));
    send_pair(make_pair(0, 0, 6, 6, 6, 6, 7, 5, 1, 0));
    // Degenerate A on line B: only skip_start decides.
    send_pair(make_pair(2, 2, 2, 2, 0, 0, 5, 5, 0, 1));
    send_pair(make_pair(2, 2, 2, 2, 0, 0, 5, 5, 1, 0));
    // Degenerate B.
    send_pair(make_pair(0, 0, 6, 6, 3, 1, 3, 1, 0, 0));
    // Extreme coordinates; the steep B clamps the crossing to 64 bits.
    send_pair(make_pair(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 9,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF, 0, 0));
    send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1));
    send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
                        32'h8000_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFD, 0, 0));
    send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, 1, 1));
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_pair(random_pair());
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall
  // the input, while the sender keeps offering beats.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 150;
    repeat (120) send_pair(random_pair());
  endtask

  // The sender stops until every result is back, then resumes.
  task automatic test_drain_pause();
    in_if.valid <= 1'b0;
    wait (pending_crossings.size() == 0);
    @(posedge clk);
    repeat (30) send_pair(random_pair());
  endtask

  initial begin
    in_if.valid      <= 1'b0;
    in_if.a_start_x  <= '0;
    in_if.a_start_y  <= '0;
    in_if.a_end_x    <= '0;
    in_if.a_end_y    <= '0;
    in_if.b_start_x  <= '0;
    in_if.b_start_y  <= '0;
    in_if.b_end_x    <= '0;
    in_if.b_end_y    <= '0;
    in_if.skip_start <= 1'b0;
    in_if.skip_end   <= 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(300, 16, 61);
    test_backpressure();
    test_random(300, 61, 16);
    test_drain_pause();
    test_random(280, 0, 0);

    in_if.valid <= 1'b0;
    wait (pending_crossings.size() == 0);
    // Leave room for any stray result to show up.
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_crossings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
